[sv/fdl_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the fractional delay line.
package fdl_pkg;

  localparam int DEF_STORE_LENGTH  = 4096;
  localparam int DEF_SAMPLE_BITS   = 24;
  localparam int DEF_FRACTION_BITS = 16;

  // Result queue between the interpolator and the output channel.
  localparam int OUTQ_DEPTH    = 4;
  localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_BITS = $clog2(OUTQ_DEPTH + 1);

  // Qualifiers that travel with each store read.
  typedef struct packed {
    logic fwd;  // use the sample written in the same cycle as the read
    logic ok;   // entry has been written since reset
  } fdl_rd_info_t;

  // Occupancy of the interpolator stages.
  typedef struct packed {
    logic s1;  // base sample arrives, base product formed
    logic s2;  // neighbor sample arrives, neighbor product formed
    logic s3;  // products summed, result pushed
  } fdl_pipe_t;

endpackage

[sv/fdl_in_if.sv]
`timescale 1ns / 1ps
// Input sample channel with valid/ready handshake.
interface fdl_in_if import fdl_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

[sv/fdl_out_if.sv]
`timescale 1ns / 1ps
// Output sample channel with valid/ready handshake.
interface fdl_out_if import fdl_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

[sv/fdl_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module fdl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/fdl_addr.sv]
`timescale 1ns / 1ps
// Write index, read position, fill count and lag register of the delay line.
module fdl_addr import fdl_pkg::*; #(
  parameter int STORE_LENGTH  = DEF_STORE_LENGTH,
  parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  localparam int AW           = $clog2(STORE_LENGTH),
  localparam int LAG_BITS     = AW + FRACTION_BITS,
  localparam int CW           = $clog2(STORE_LENGTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     lag_we,
  input  logic [LAG_BITS-1:0]      lag_wdata,
  input  logic                     accept,
  input  logic [SAMPLE_BITS-1:0]   sample,
  input  logic                     second_read,
  output logic                     busy,
  output logic                     ram_we,
  output logic [AW-1:0]            ram_waddr,
  output logic [SAMPLE_BITS-1:0]   ram_wdata,
  output logic [AW-1:0]            ram_raddr,
  output fdl_rd_info_t             rd_info,
  output logic [SAMPLE_BITS-1:0]   fwd_sample,
  output logic [FRACTION_BITS-1:0] alpha
);

  localparam int PW = LAG_BITS + 1;
  localparam logic [PW-1:0]       SPAN      = PW'(STORE_LENGTH) << FRACTION_BITS;
  localparam logic [AW-1:0]       LAST      = AW'(STORE_LENGTH - 1);
  localparam logic [AW-1:0]       HALF      = AW'(STORE_LENGTH / 2);
  localparam logic [AW-1:0]       OFF_RESET = AW'(STORE_LENGTH - STORE_LENGTH / 2);
  localparam logic [CW-1:0]       FULL      = CW'(STORE_LENGTH);
  localparam logic [LAG_BITS-1:0] LAG_RESET = LAG_BITS'(STORE_LENGTH / 2) << FRACTION_BITS;

  logic [AW-1:0]            wi;
  logic [AW-1:0]            base;
  logic [AW-1:0]            off;    // base measured from the first written entry
  logic [CW-1:0]            fill;
  logic [LAG_BITS-1:0]      lag;
  logic                     recalc_a;
  logic                     recalc_b;

  logic [PW-1:0]            pos_diff;
  logic [PW-1:0]            pos;
  logic [AW-1:0]            off_calc;
  logic [LAG_BITS-1:0]      lag_sat;
  logic                     base_ok_now;
  logic                     base_ok_next;

  // Read position of the next item, recomputed only after a lag write.
  always_comb begin
    pos_diff = {1'b0, wi, {FRACTION_BITS{1'b0}}} - {1'b0, lag};
    pos      = pos_diff[PW-1] ? pos_diff + SPAN : pos_diff;
    off_calc = (base >= HALF) ? base - HALF : base + OFF_RESET;
    lag_sat  = ({1'b0, lag_wdata} >= SPAN) ? LAG_BITS'(SPAN - 1'b1) : lag_wdata;
    // The entry at the write index counts as written during its own write.
    base_ok_now  = CW'(off) <= fill;
    base_ok_next = CW'(off) < fill;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wi       <= HALF;
      base     <= '0;
      off      <= OFF_RESET;
      fill     <= '0;
      lag      <= LAG_RESET;
      alpha    <= '0;
      recalc_a <= 1'b0;
      recalc_b <= 1'b0;
      rd_info  <= '0;
    end else begin
      recalc_a <= lag_we;
      recalc_b <= recalc_a;
      if (lag_we) begin
        lag <= lag_sat;
      end
      if (recalc_a) begin
        base  <= pos[LAG_BITS-1:FRACTION_BITS];
        alpha <= pos[FRACTION_BITS-1:0];
      end
      if (recalc_b) begin
        off <= off_calc;
      end
      if (accept) begin
        wi   <= (wi == LAST) ? '0 : wi + 1'b1;
        base <= (base == LAST) ? '0 : base + 1'b1;
        off  <= (off == LAST) ? '0 : off + 1'b1;
        if (fill != FULL) begin
          fill <= fill + 1'b1;
        end
      end
      if (accept) begin
        rd_info.fwd <= (base == wi);
        rd_info.ok  <= base_ok_now;
      end else if (second_read) begin
        rd_info.fwd <= 1'b0;
        rd_info.ok  <= base_ok_next;
      end else begin
        rd_info <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_sample <= sample;
    end
  end

  // The base pointer already points at the neighbor in the cycle after accept.
  assign ram_raddr = base;
  assign ram_we    = accept;
  assign ram_waddr = wi;
  assign ram_wdata = sample;
  assign busy      = recalc_a | recalc_b;

endmodule

[sv/fdl_interp.sv]
`timescale 1ns / 1ps
// Linear interpolator with one multiplier shared by the base and neighbor products.
module fdl_interp import fdl_pkg::*; #(
  parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  fdl_rd_info_t             rd_info,
  input  logic [SAMPLE_BITS-1:0]   rd_data,
  input  logic [SAMPLE_BITS-1:0]   fwd_sample,
  input  logic [FRACTION_BITS-1:0] alpha,
  output fdl_pipe_t                pipe,
  output logic                     res_valid,
  output logic [SAMPLE_BITS-1:0]   res_data
);

  localparam int PROD_W = SAMPLE_BITS + FRACTION_BITS + 1;
  localparam logic [SAMPLE_BITS-1:0] SIGN = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
  localparam logic [FRACTION_BITS:0] ONE  = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;

  logic [SAMPLE_BITS-1:0]   sel;
  logic [SAMPLE_BITS-1:0]   op_a;
  logic [FRACTION_BITS:0]   op_b;
  logic [FRACTION_BITS:0]   om;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        base_prod;
  logic [PROD_W-1:0]        next_prod;
  logic [PROD_W-1:0]        sum;

  // Samples are handled in offset binary so the truncating shift is a floor.
  always_comb begin
    sel  = rd_info.fwd ? fwd_sample : (rd_info.ok ? rd_data : '0);
    op_a = sel ^ SIGN;
    om   = ONE - {1'b0, alpha};
    op_b = pipe.s1 ? om : {1'b0, alpha};
    prod = {{(FRACTION_BITS + 1){1'b0}}, op_a} * {{SAMPLE_BITS{1'b0}}, op_b};
    sum  = base_prod + next_prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe <= '0;
    end else begin
      pipe.s1 <= start;
      pipe.s2 <= pipe.s1;
      pipe.s3 <= pipe.s2;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.s1) begin
      base_prod <= prod;
    end
    if (pipe.s2) begin
      next_prod <= prod;
    end
  end

  assign res_valid = pipe.s3;
  assign res_data  = sum[SAMPLE_BITS+FRACTION_BITS-1:FRACTION_BITS] ^ SIGN;

endmodule

[sv/fdl_outq.sv]
`timescale 1ns / 1ps
// Small result queue that drives the output channel.
module fdl_outq import fdl_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic [SAMPLE_BITS-1:0]   push_data,
  fdl_out_if.source                out_ch,
  output logic [OUTQ_CNT_BITS-1:0] count
);

  logic [SAMPLE_BITS-1:0]   mem [OUTQ_DEPTH];
  logic [OUTQ_PTR_BITS-1:0] wr_ptr;
  logic [OUTQ_PTR_BITS-1:0] rd_ptr;
  logic                     pop;

  assign out_ch.valid      = (count != '0);
  assign out_ch.sample_out = mem[rd_ptr];
  assign pop               = out_ch.valid & out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

[sv/fractional_delay_line.sv]
`timescale 1ns / 1ps
// Linearly interpolated fractional delay line, top level.
// Path: an accepted item passes the interpolator stages s1, s2 and s3, then waits in the output queue.
// Each item takes two reads of the single store read port, so input is closed while its second read runs.
// Reset: index at half the store, lag half the store; the store is not swept, a fill
// count makes never-written entries read as zero. A lag write stalls input while the base is recomputed.
module fractional_delay_line import fdl_pkg::*; #(
  parameter int STORE_LENGTH  = DEF_STORE_LENGTH,
  parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  localparam int AW           = $clog2(STORE_LENGTH),
  localparam int LAG_BITS     = AW + FRACTION_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                delay_lag_we,
  input  logic [LAG_BITS-1:0] delay_lag_wdata,
  fdl_in_if.sink              in_ch,
  fdl_out_if.source           out_ch
);

  localparam int OCC_W = OUTQ_CNT_BITS + 1;

  // Store interface signals.
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [SAMPLE_BITS-1:0]   ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [SAMPLE_BITS-1:0]   ram_rdata;

  // Control between the address unit and the interpolator.
  logic                     accept;
  logic                     busy;
  fdl_rd_info_t             rd_info;
  fdl_pipe_t                pipe;
  logic [SAMPLE_BITS-1:0]   fwd_sample;
  logic [FRACTION_BITS-1:0] alpha;
  logic                     res_valid;
  logic [SAMPLE_BITS-1:0]   res_data;
  logic [OUTQ_CNT_BITS-1:0] q_count;
  logic [OCC_W-1:0]         occupancy;

  // An item needs the read port in its accept cycle and the cycle after, so the
  // cycle after an accept is closed. Every item still in the interpolator has a
  // queue slot reserved, so a full output side holds off new items instead of
  // stalling the pipeline.
  assign occupancy = OCC_W'(pipe.s2) + OCC_W'(pipe.s3) + OCC_W'(q_count);
  assign in_ch.ready = !pipe.s1 && !busy && (occupancy < OCC_W'(OUTQ_DEPTH));
  assign accept      = in_ch.valid & in_ch.ready;

  // The address unit writes the new sample and issues the base read in the
  // accept cycle, then the neighbor read in the following cycle.
  fdl_addr #(
    .STORE_LENGTH  (STORE_LENGTH),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_addr (
    .clk         (clk),
    .rst         (rst),
    .lag_we      (delay_lag_we),
    .lag_wdata   (delay_lag_wdata),
    .accept      (accept),
    .sample      (in_ch.sample_in),
    .second_read (pipe.s1),
    .busy        (busy),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .rd_info     (rd_info),
    .fwd_sample  (fwd_sample),
    .alpha       (alpha)
  );

  // Circular sample store.
  fdl_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (STORE_LENGTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Weighted sum of the base and neighbor samples.
  fdl_interp #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_interp (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .rd_info    (rd_info),
    .rd_data    (ram_rdata),
    .fwd_sample (fwd_sample),
    .alpha      (alpha),
    .pipe       (pipe),
    .res_valid  (res_valid),
    .res_data   (res_data)
  );

  // Results wait here until the downstream side takes them.
  fdl_outq #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_data),
    .out_ch    (out_ch),
    .count     (q_count)
  );

endmodule
